/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros for the matrix multiply checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("matrix multiply assertion failed");

// checked in and out of reset
`define MM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("matrix multiply assertion failed");

`endif

/* hdl/mm_pkg.sv */
// ----------------------------------------------------------------------------
// mm_pkg
// shared types and codes of the matrix multiply block
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int ROW_W = 4;
  localparam int VAL_W = 16;
  localparam int RES_W = 36;
  localparam int DIM_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [ROW_W-1:0]        row_index;
    logic [ROW_W-1:0]        col_index;
    logic signed [VAL_W-1:0] element_value;
  } req_t;

  typedef struct packed {
    logic signed [RES_W-1:0] product_value;
    logic [ROW_W-1:0]        out_row;
    logic [ROW_W-1:0]        out_col;
    logic                    last;
  } res_t;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_COMPUTE
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] inner_size;
    logic [DIM_W-1:0] cols_b;
  } sizes_t;

endpackage

/* hdl/mm_front.sv */
// ----------------------------------------------------------------------------
// mm_front
// request intake, size registers and range filtering of items
// ----------------------------------------------------------------------------
module mm_front #(
  parameter int MAX_DIM = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  mm_pkg::req_t                  req,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]      cfg_data,
  output mm_pkg::sizes_t                sizes,
  output logic                          op_valid,
  input  logic                          op_full,
  output mm_pkg::op_t                   op
);
  import mm_pkg::*;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic [DIM_W-1:0] rows_a;
  logic [DIM_W-1:0] inner_size;
  logic [DIM_W-1:0] cols_b;
  logic             hold_valid;
  req_t             hold;
  logic             keep;
  logic             done;
  logic             accept;
  logic [DIM_W-1:0] row_x;
  logic [DIM_W-1:0] col_x;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= DIM_RESET;
      inner_size <= DIM_RESET;
      cols_b     <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS_A:     rows_a     <= cfg_data;
        CFG_INNER_SIZE: inner_size <= cfg_data;
        CFG_COLS_B:     cols_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sizes.rows_a     = (rows_a > DIM_MAX) ? DIM_MAX : rows_a;
  assign sizes.inner_size = (inner_size > DIM_MAX) ? DIM_MAX : inner_size;
  assign sizes.cols_b     = (cols_b > DIM_MAX) ? DIM_MAX : cols_b;

  assign row_x = {1'b0, hold.row_index};
  assign col_x = {1'b0, hold.col_index};

  always_comb begin
    keep     = 1'b0;
    op.kind  = OP_COMPUTE;
    op.row   = hold.row_index;
    op.col   = hold.col_index;
    op.value = hold.element_value;
    unique case (hold.req_type)
      REQ_LOAD_A: begin
        keep    = (row_x < sizes.rows_a) && (col_x < sizes.inner_size);
        op.kind = OP_LOAD_A;
      end
      REQ_LOAD_B: begin
        keep    = (row_x < sizes.inner_size) && (col_x < sizes.cols_b);
        op.kind = OP_LOAD_B;
      end
      REQ_COMPUTE: begin
        keep    = (row_x < sizes.rows_a) && (sizes.cols_b != '0);
        op.kind = OP_COMPUTE;
      end
      default: keep = 1'b0;
    endcase
  end

  // dropped items retire at once, kept ones when the queue takes them
  assign op_valid  = hold_valid && keep;
  assign done      = hold_valid && (!keep || !op_full);
  assign req_stall = hold_valid && !done;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (done) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= req;
    end
  end

endmodule

/* hdl/mm_queue.sv */
// ----------------------------------------------------------------------------
// mm_queue
// short in-order queue of filtered items between intake and execution
// ----------------------------------------------------------------------------
module mm_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  mm_pkg::op_t push_op,
  output logic        full,
  input  logic        pop,
  output mm_pkg::op_t pop_op,
  output logic        empty
);
  import mm_pkg::*;

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

/* hdl/mm_back.sv */
// ----------------------------------------------------------------------------
// mm_back
// element stores and the multiply-accumulate sequencer for result rows
// ----------------------------------------------------------------------------
module mm_back #(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  mm_pkg::sizes_t sizes,
  input  logic           op_empty,
  input  mm_pkg::op_t    op,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_stall,
  output mm_pkg::res_t   res
);
  import mm_pkg::*;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int ACC_W  = PROD_W + 5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } state_t;

  logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];

  state_t                       state;
  logic [ROW_W-1:0]             row_r;
  logic [IDX_W-1:0]             j;
  logic [IDX_W-1:0]             k;
  logic                         k_last;
  logic                         j_last;
  logic                         no_terms;
  logic                         out_free;
  logic                         emit;
  logic                         rd_en;
  logic                         wr_a;
  logic                         wr_b;
  logic [ADDR_W-1:0]            waddr;
  logic [ADDR_W-1:0]            raddr_a;
  logic [ADDR_W-1:0]            raddr_b;
  logic signed [ELEM_WIDTH-1:0] elem_in;
  logic signed [ELEM_WIDTH-1:0] rd_a;
  logic signed [ELEM_WIDTH-1:0] rd_b;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      acc;
  logic                         s1_v;
  logic                         s1_first;
  logic                         s1_last;
  logic                         s2_v;
  logic                         s2_first;
  logic                         s2_last;
  logic                         done_r;
  res_t                         res_next;

  assign pop     = (state == S_IDLE) && !op_empty;
  assign wr_a    = pop && (op.kind == OP_LOAD_A);
  assign wr_b    = pop && (op.kind == OP_LOAD_B);
  assign waddr   = ADDR_W'(op.row * MAX_DIM + op.col);
  assign elem_in = ELEM_WIDTH'($signed(op.value));

  assign rd_en   = (state == S_RUN);
  assign raddr_a = ADDR_W'(row_r * MAX_DIM + k);
  assign raddr_b = ADDR_W'(k * MAX_DIM + j);

  assign k_last   = (DIM_W'(k) + DIM_W'(1)) == sizes.inner_size;
  assign j_last   = (DIM_W'(j) + DIM_W'(1)) == sizes.cols_b;
  assign no_terms = (sizes.inner_size == '0);
  assign out_free = !res_valid || !res_stall;
  assign emit     = (state == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[waddr] <= elem_in;
    end
    if (rd_en) begin
      rd_a <= mem_a[raddr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[waddr] <= elem_in;
    end
    if (rd_en) begin
      rd_b <= mem_b[raddr_b];
    end
  end

  // read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      done_r   <= 1'b0;
      s1_first <= 1'b0;
      s1_last  <= 1'b0;
      s2_first <= 1'b0;
      s2_last  <= 1'b0;
    end else begin
      s1_v     <= rd_en;
      s1_first <= (k == '0);
      s1_last  <= k_last;
      s2_v     <= s1_v;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      done_r   <= s2_v && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      prod <= rd_a * rd_b;
    end
    if (s2_v) begin
      acc <= (s2_first ? ACC_W'(0) : acc) + ACC_W'(prod);
    end
  end

  assign res_next.product_value = no_terms ? RES_W'(0) : RES_W'(acc);
  assign res_next.out_row       = row_r;
  assign res_next.out_col       = ROW_W'(j);
  assign res_next.last          = j_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      row_r     <= '0;
      j         <= '0;
      k         <= '0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
        res       <= res_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop && (op.kind == OP_COMPUTE)) begin
            row_r <= op.row;
            j     <= '0;
            k     <= '0;
            state <= no_terms ? S_EMIT : S_RUN;
          end
        end
        S_RUN: begin
          k <= k + IDX_W'(1);
          if (k_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (done_r) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            k <= '0;
            if (j_last) begin
              state <= S_IDLE;
            end else begin
              j     <= j + IDX_W'(1);
              state <= no_terms ? S_EMIT : S_RUN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/matrix_multiply.sv */
// ----------------------------------------------------------------------------
// matrix_multiply
// fixed-point matrix multiply, one result row of C = A x B per compute item
//
//   channel  signals                              carries
//   req      req_valid, req_stall, req            load A, load B or compute
//   res      res_valid, res_stall, res            one element of a row of C
//   cfg      cfg_valid, cfg_ready, cfg_index/data size registers
//
// a load item is written to its store in the execution stage after the intake stage
// a compute item holds the execution stage while its row is worked out element by element,
// limited by the single multiply-accumulate unit and the one read port of each store
// reset clears the size registers to 16 and empties the queue; the
// element stores hold no defined value until written
// res_stall holds the result register; a four-entry queue keeps req open
// ----------------------------------------------------------------------------
module matrix_multiply #(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  mm_pkg::req_t                 req,
  output logic                         res_valid,
  input  logic                         res_stall,
  output mm_pkg::res_t                 res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]     cfg_data
);
  import mm_pkg::*;

  sizes_t sizes;
  op_t    push_op;
  op_t    pop_op;
  logic   push;
  logic   full;
  logic   pop;
  logic   empty;

  mm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sizes     (sizes),
    .op_valid  (push),
    .op_full   (full),
    .op        (push_op)
  );

  mm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (empty)
  );

  mm_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .sizes     (sizes),
    .op_empty  (empty),
    .op        (pop_op),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

/* hdl/mm_checker.sv */
// ----------------------------------------------------------------------------
// mm_checker
// port-level checks of result ordering, output holding and quiet outputs after reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mm_checker (
  input logic         clk,
  input logic         rst,
  input logic         req_stall,
  input logic         res_valid,
  input logic         res_stall,
  input mm_pkg::res_t res
);
  import mm_pkg::*;

  logic             res_accept;
  logic             prev_open;
  logic [ROW_W-1:0] prev_row;
  logic [ROW_W-1:0] prev_col;

  assign res_accept = res_valid && !res_stall;

  // a row is open after an item that is not the last of its row
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_open <= 1'b0;
      prev_row  <= '0;
      prev_col  <= '0;
    end else if (res_accept) begin
      prev_open <= !res.last;
      prev_row  <= res.out_row;
      prev_col  <= res.out_col;
    end
  end

  `MM_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res))
  `MM_ASSERT(a_row_next, res_accept && prev_open |-> res.out_row == prev_row && res.out_col == prev_col + 4'd1)
  `MM_ASSERT(a_row_first, res_accept && !prev_open |-> res.out_col == '0)
  `MM_ASSERT_ALWAYS(a_rst_quiet, rst |=> !res_valid && !req_stall)

endmodule

bind matrix_multiply mm_checker u_mm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

/* bench/matrix_multiply_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_tb
// self-checking bench for the fixed-point matrix multiply block
//
// loads elements of A and B and asks for rows of C, under several size
// settings; a scoreboard keeps its own copy of both stores and of the size
// registers, works out every expected row element and compares each result
// item field by field; both channels idle and stall at random, and the
// result side holds off once long enough to back the block up
// ----------------------------------------------------------------------------
module matrix_multiply_tb;
  import mm_pkg::*;

  localparam int MAX_DIM = 16;
  localparam int RANDOM_ITEMS = 350;
  localparam int DRAIN_CYCLES = 1800;
  localparam int HOLD_CYCLES = 1500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  class mm_scoreboard;
    logic signed [VAL_W-1:0] elem_a[MAX_DIM*MAX_DIM];
    logic signed [VAL_W-1:0] elem_b[MAX_DIM*MAX_DIM];
    bit seen_a[MAX_DIM*MAX_DIM];
    bit seen_b[MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0] reg_rows;
    logic [DIM_W-1:0] reg_inner;
    logic [DIM_W-1:0] reg_cols;
    res_t row_q[$];
    int errors;

    function new();
      for (int i = 0; i < MAX_DIM*MAX_DIM; i++) begin
        elem_a[i] = '0;
        elem_b[i] = '0;
        seen_a[i] = 0;
        seen_b[i] = 0;
      end
      reg_rows = DIM_RESET;
      reg_inner = DIM_RESET;
      reg_cols = DIM_RESET;
      errors = 0;
    endfunction

    function int dim(logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function int rows();
      return dim(reg_rows);
    endfunction

    function int inner();
      return dim(reg_inner);
    endfunction

    function int cols();
      return dim(reg_cols);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        CFG_ROWS_A: reg_rows = data;
        CFG_INNER_SIZE: reg_inner = data;
        CFG_COLS_B: reg_cols = data;
        default: ;
      endcase
    endfunction

    function bit row_ready(int r);
      for (int k = 0; k < inner(); k++) begin
        if (!seen_a[r*MAX_DIM+k]) return 0;
        for (int j = 0; j < cols(); j++)
          if (!seen_b[k*MAX_DIM+j]) return 0;
      end
      return 1;
    endfunction

    function bit has_effect(req_t it);
      case (it.req_type)
        REQ_LOAD_A: return it.row_index < rows() && it.col_index < inner();
        REQ_LOAD_B: return it.row_index < inner() && it.col_index < cols();
        REQ_COMPUTE: return it.row_index < rows() && cols() > 0;
        default: return 0;
      endcase
    endfunction

    function void note_input(req_t it);
      res_t exp_res;
      longint acc;
      int r;
      r = it.row_index;
      if (!has_effect(it)) return;
      case (it.req_type)
        REQ_LOAD_A: begin
          elem_a[r*MAX_DIM+it.col_index] = it.element_value;
          seen_a[r*MAX_DIM+it.col_index] = 1;
        end
        REQ_LOAD_B: begin
          elem_b[r*MAX_DIM+it.col_index] = it.element_value;
          seen_b[r*MAX_DIM+it.col_index] = 1;
        end
        default: begin
          for (int j = 0; j < cols(); j++) begin
            acc = 0;
            for (int k = 0; k < inner(); k++)
              acc += longint'(elem_a[r*MAX_DIM+k]) * longint'(elem_b[k*MAX_DIM+j]);
            exp_res.product_value = acc[RES_W-1:0];
            exp_res.out_row = it.row_index;
            exp_res.out_col = j[ROW_W-1:0];
            exp_res.last = (j == cols() - 1);
            row_q = {row_q, exp_res};
          end
        end
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (row_q.size() == 0) begin
        $error("result item with no expected item: product_value %0d row %0d col %0d",
               got.product_value, got.out_row, got.out_col);
        errors++;
        return;
      end
      want = row_q.pop_front();
      if (got.product_value !== want.product_value) begin
        $error("product_value expected %0d actual %0d", want.product_value, got.product_value);
        errors++;
      end
      if (got.out_row !== want.out_row) begin
        $error("out_row expected %0d actual %0d", want.out_row, got.out_row);
        errors++;
      end
      if (got.out_col !== want.out_col) begin
        $error("out_col expected %0d actual %0d", want.out_col, got.out_col);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return row_q.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  mm_scoreboard sb = new();
  bit tx_burst = 0;
  bit hold_req = 0;
  int effective_total = 0;
  int sent_total = 0;
  int idle_cycles = 0;

  matrix_multiply DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res);
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stall per item, quiet stretches, one long hold-off
  initial begin
    int wait_cycles;
    int taken;
    bit rx_burst;
    taken = 0;
    rx_burst = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = rx_burst ? 0 : $urandom_range(0, 12);
      if (hold_req) begin
        wait_cycles = HOLD_CYCLES;
        hold_req = 0;
      end
      if (wait_cycles > 0) begin
        res_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      taken++;
      if (taken % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  task automatic send_item(req_t it);
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (sb.has_effect(it)) effective_total++;
    sent_total++;
    sb.note_input(it);
  endtask

  task automatic offer(req_t it);
    int gap;
    send_item(it);
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic req_t make_item(logic [1:0] kind, int row, int col,
                                     logic [VAL_W-1:0] value);
    req_t it;
    it.req_type = kind;
    it.row_index = row[ROW_W-1:0];
    it.col_index = col[ROW_W-1:0];
    it.element_value = value;
    return it;
  endfunction

  function automatic logic [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] draw_dim();
    int pick;
    pick = $urandom_range(0, 12);
    if (pick < 10) return DIM_W'($urandom_range(1, 4));
    if (pick == 10) return 5'd16;
    if (pick == 11) return DIM_W'($urandom_range(17, 31));
    return 5'd0;
  endfunction

  // block idle: every expected item in, then time for queued no-result items
  task automatic settle();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sizes(logic [DIM_W-1:0] ra, logic [DIM_W-1:0] kn,
                           logic [DIM_W-1:0] cb);
    cfg_write(CFG_ROWS_A, ra);
    cfg_write(CFG_INNER_SIZE, kn);
    cfg_write(CFG_COLS_B, cb);
  endtask

  task automatic noise_item();
    req_t it;
    it = make_item(2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 15),
                   draw_value());
    // never read an element that was not loaded
    if (it.req_type == REQ_COMPUTE && it.row_index < sb.rows() &&
        !sb.row_ready(it.row_index))
      it.req_type = REQ_UNKNOWN;
    offer(it);
  endtask

  // fill what the row needs, maybe overwrite a few elements, then compute it; with no rows, one compute that is dropped
  task automatic row_sequence();
    int r;
    int n;
    if (sb.rows() == 0) begin
      offer(make_item(REQ_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                      VAL_W'($urandom)));
      return;
    end
    r = $urandom_range(0, sb.rows() - 1);
    for (int k = 0; k < sb.inner(); k++)
      if (!sb.seen_a[r*MAX_DIM+k]) offer(make_item(REQ_LOAD_A, r, k, draw_value()));
    for (int k = 0; k < sb.inner(); k++)
      for (int j = 0; j < sb.cols(); j++)
        if (!sb.seen_b[k*MAX_DIM+j]) offer(make_item(REQ_LOAD_B, k, j, draw_value()));
    if (sb.inner() > 0 && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0)
          offer(make_item(REQ_LOAD_A, r, $urandom_range(0, sb.inner() - 1), draw_value()));
        else if (sb.cols() > 0)
          offer(make_item(REQ_LOAD_B, $urandom_range(0, sb.inner() - 1),
                          $urandom_range(0, sb.cols() - 1), draw_value()));
      end
    end
    offer(make_item(REQ_COMPUTE, r, $urandom_range(0, 15), VAL_W'($urandom)));
  endtask

  initial begin
    int phase;
    int phase_start;
    int phase_len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes of the element, loads outside the sizes, odd requests
    set_sizes(5'd2, 5'd1, 5'd2);
    tx_burst = 0;
    offer(make_item(REQ_LOAD_A, 0, 0, 16'h7FFF));
    offer(make_item(REQ_LOAD_A, 1, 0, 16'h8000));
    offer(make_item(REQ_LOAD_B, 0, 0, 16'h8000));
    offer(make_item(REQ_LOAD_B, 0, 1, 16'h7FFF));
    offer(make_item(REQ_LOAD_A, 2, 0, 16'hFFFF));
    offer(make_item(REQ_LOAD_A, 0, 1, 16'hFFFF));
    offer(make_item(REQ_LOAD_B, 1, 0, 16'hFFFF));
    offer(make_item(REQ_LOAD_B, 0, 2, 16'hFFFF));
    offer(make_item(REQ_LOAD_B, 15, 15, 16'h0000));
    offer(make_item(REQ_UNKNOWN, 15, 15, 16'hFFFF));
    offer(make_item(REQ_COMPUTE, 0, 15, 16'hFFFF));
    offer(make_item(REQ_COMPUTE, 1, 0, 16'h0000));
    offer(make_item(REQ_COMPUTE, 2, 0, 16'h0000));
    offer(make_item(REQ_COMPUTE, 15, 0, 16'h0000));
    settle();
    cfg_write(CFG_ROWS_A, 5'd0);
    offer(make_item(REQ_COMPUTE, 0, 0, 16'h0000));
    settle();
    cfg_write(CFG_ROWS_A, 5'd31);
    cfg_write(CFG_INNER_SIZE, 5'd0);
    offer(make_item(REQ_LOAD_A, 3, 0, 16'h1234));
    offer(make_item(REQ_COMPUTE, 15, 0, 16'h0000));
    settle();
    cfg_write(CFG_COLS_B, 5'd0);
    cfg_write(CFG_UNUSED, 5'd31);
    offer(make_item(REQ_COMPUTE, 15, 0, 16'h0000));

    // random phases
    effective_total = 0;
    phase = 0;
    while (effective_total < RANDOM_ITEMS) begin
      settle();
      case (phase)
        0: set_sizes(5'd16, 5'd16, 5'd1);
        1: set_sizes(5'd1, 5'd1, 5'd16);
        2: set_sizes(5'd4, 5'd2, 5'd4);
        default: set_sizes(draw_dim(), draw_dim(), draw_dim());
      endcase
      tx_burst = (phase == 2) || ($urandom_range(0, 3) == 0);
      if (phase == 2) hold_req = 1;
      phase_len = $urandom_range(12, 40);
      phase_start = sent_total;
      while (sent_total - phase_start < phase_len) begin
        if ($urandom_range(0, 4) == 0)
          noise_item();
        else
          row_sequence();
      end
      phase++;
    end

    settle();
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/mm_pkg.sv
hdl/mm_front.sv
hdl/mm_queue.sv
hdl/mm_back.sv
hdl/matrix_multiply.sv
hdl/mm_checker.sv
bench/matrix_multiply_tb.sv
